[rtl/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property: whenever cond holds, expr holds in the same cycle
`define ASSERT_HOLDS(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
// property: whenever cond holds, expr holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[rtl/gcrb_pkg.sv]
// shared constants for the gradient color ramp builder
`timescale 1ns / 1ps

package gcrb_pkg;

    // color channel layout: red 7..0, green 15..8, blue 23..16, alpha 31..24
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 4;
    localparam int COLOR_W = CH_W * NUM_CH;

    // stop offset in q16 fixed point, clamped to one
    localparam int OFF_W   = 17;
    localparam int Q_FRAC  = 16;
    localparam logic [OFF_W-1:0] Q16_ONE = 17'd65536;

    // request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

endpackage

[rtl/gcrb_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module gcrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/gradient_color_ramp_builder.sv]
// top level of the gradient color ramp builder
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// One request channel (i_in_valid / o_in_ready) carries either a color stop
// load (i_func = 0) or a ramp read (i_func = 1). One response channel
// (o_out_valid / i_out_ready) returns one entry per read and nothing per load.
// A load without i_last_stop leaves o_in_ready high. A load with i_last_stop
// starts the ramp fill, during which o_in_ready is low. The fill writes one ramp
// entry per cycle through the ramp memory write port while in its head, segment
// and tail states; before a nonempty segment is written, the 4 channels pass one
// after another through the shared restoring divider, and a closing state ends
// each segment. A read is answered through the ramp memory read register, which
// loads at the accepting edge, and then through the output register, which loads
// once it is free; no new request is accepted before that. Reads before the
// first fill return zero color
// and o_ramp_ready low. The output register lets the block accept the next
// request while a response waits; a second read then waits until the receiver
// takes the first response. Reset (synchronous, active low) empties the stop
// list, forgets the ramp and drops any pending response.

module gradient_color_ramp_builder #(
    parameter int RAMP_SIZE = 256,
    parameter int MAX_STOPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_func,
    input  logic [16:0] i_stop_offset,
    input  logic [7:0] i_stop_red,
    input  logic [7:0] i_stop_green,
    input  logic [7:0] i_stop_blue,
    input  logic [7:0] i_stop_alpha,
    input  logic       i_last_stop,
    input  logic [7:0] i_read_index,
    // response channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_entry_red,
    output logic [7:0] o_entry_green,
    output logic [7:0] o_entry_blue,
    output logic [7:0] o_entry_alpha,
    output logic       o_ramp_ready
);

    localparam int CH_W    = gcrb_pkg::CH_W;
    localparam int NUM_CH  = gcrb_pkg::NUM_CH;
    localparam int COLOR_W = gcrb_pkg::COLOR_W;
    localparam int OFF_W   = gcrb_pkg::OFF_W;
    localparam int STOP_W  = OFF_W + COLOR_W;
    localparam int IW      = $clog2(RAMP_SIZE);
    localparam int SAW     = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW      = $clog2(MAX_STOPS + 1);
    localparam int PW      = OFF_W + IW;
    localparam int CHW     = $clog2(NUM_CH);
    localparam int BW      = $clog2(CH_W);
    localparam logic [IW-1:0] LAST_IDX = IW'(RAMP_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDW,
        S_FRD,
        S_FMUL,
        S_FNEXT,
        S_HEAD,
        S_DVLD,
        S_DIV,
        S_SEG,
        S_FDONE,
        S_TAIL
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [OFF_W-1:0]    r_last_off;
    logic                r_built;
    logic [SAW-1:0]      r_i;
    logic [IW-1:0]       r_t;
    logic [IW-1:0]       r_s;
    logic [IW-1:0]       r_e;
    logic [IW-1:0]       r_len;
    logic [COLOR_W-1:0]  r_ca;
    logic [COLOR_W-1:0]  r_cb;
    logic [CHW-1:0]      r_ch;
    logic [BW-1:0]       r_bit;
    logic [CH_W-1:0]     r_dvd;
    logic [IW-1:0]       r_drem;
    logic [CH_W-1:0]     r_qstep [NUM_CH];
    logic [IW-1:0]       r_rstep [NUM_CH];
    logic [CH_W-1:0]     r_qacc  [NUM_CH];
    logic [IW-1:0]       r_racc  [NUM_CH];
    logic [NUM_CH-1:0]   r_neg;
    logic                r_out_valid;
    logic [COLOR_W-1:0]  r_out_col;
    logic                r_out_built;

    logic                w_accept;
    logic [OFF_W-1:0]    w_off;
    logic [COLOR_W-1:0]  w_col;
    logic                w_stop_we;
    logic [SAW-1:0]      w_stop_waddr;
    logic [STOP_W-1:0]   w_stop_rdata;
    logic [OFF_W-1:0]    w_stop_off;
    logic [PW-1:0]       w_prod;
    logic                w_ramp_we;
    logic [COLOR_W-1:0]  w_ramp_wdata;
    logic [COLOR_W-1:0]  w_blend;
    logic [COLOR_W-1:0]  w_ramp_rdata;
    logic [IW-1:0]       w_rd_idx;
    logic                w_ramp_re;
    logic                w_is_last;
    logic                w_out_free;
    logic [CH_W-1:0]     w_a_ch;
    logic [CH_W-1:0]     w_b_ch;
    logic [IW:0]         w_rem_sh;
    logic                w_q_bit;
    logic [IW-1:0]       w_rem_nx;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // clamp offset to one, pack color
    assign w_off = (i_stop_offset > gcrb_pkg::Q16_ONE) ? gcrb_pkg::Q16_ONE : i_stop_offset;
    assign w_col = {i_stop_alpha, i_stop_blue, i_stop_green, i_stop_red};

    // stop list filter: append on greater offset while the list has room, replace on equal offset
    always_comb begin
        w_stop_we    = 1'b0;
        w_stop_waddr = '0;
        if (w_accept && (i_func == gcrb_pkg::FUNC_LOAD)) begin
            if (r_count == '0) begin
                w_stop_we = 1'b1;
            end else if (r_last_off < w_off) begin
                w_stop_we    = (r_count < CW'(MAX_STOPS));
                w_stop_waddr = SAW'(r_count);
            end else if (r_last_off == w_off) begin
                w_stop_we    = 1'b1;
                w_stop_waddr = SAW'(r_count - 1'b1);
            end
        end
    end

    gcrb_ram #(
        .WIDTH (STOP_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_stop_we),
        .i_wr_addr (w_stop_waddr),
        .i_wr_data ({w_off, w_col}),
        .i_rd_en   (r_state == S_FRD),
        .i_rd_addr (r_i),
        .o_rd_data (w_stop_rdata)
    );

    // ramp index of a stop: floor(offset * (RAMP_SIZE - 1) / 65536)
    assign w_stop_off = w_stop_rdata[COLOR_W +: OFF_W];
    assign w_prod     = {{IW{1'b0}}, w_stop_off} * {{OFF_W{1'b0}}, LAST_IDX};

    assign w_is_last = (CW'(r_i) == CW'(r_count - 1'b1));

    // shared restoring divider step: |b - a| / len, one quotient bit a cycle
    assign w_rem_sh = {r_drem, r_dvd[CH_W-1]};
    assign w_q_bit  = (w_rem_sh >= {1'b0, r_len});
    assign w_rem_nx = w_q_bit ? IW'(w_rem_sh - {1'b0, r_len}) : IW'(w_rem_sh);
    assign w_a_ch   = r_ca[r_ch*CH_W +: CH_W];
    assign w_b_ch   = r_cb[r_ch*CH_W +: CH_W];

    // interpolated entry: a +/- floor(|b - a| * k / len) per channel
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_neg[c]) begin
                w_blend[c*CH_W +: CH_W] = r_ca[c*CH_W +: CH_W] - r_qacc[c];
            end else begin
                w_blend[c*CH_W +: CH_W] = r_ca[c*CH_W +: CH_W] + r_qacc[c];
            end
        end
    end

    // ramp memory write select
    always_comb begin
        w_ramp_we    = 1'b0;
        w_ramp_wdata = r_ca;
        case (r_state)
            S_HEAD: begin
                w_ramp_we    = (r_t != r_e);
                w_ramp_wdata = r_cb;
            end
            S_SEG: begin
                w_ramp_we    = (r_t != r_e);
                w_ramp_wdata = w_blend;
            end
            S_TAIL: begin
                w_ramp_we    = 1'b1;
                w_ramp_wdata = r_ca;
            end
            default: begin
                w_ramp_we = 1'b0;
            end
        endcase
    end

    // read index saturates to the last entry
    assign w_rd_idx  = (int'(i_read_index) > (RAMP_SIZE - 1)) ? LAST_IDX : IW'(i_read_index);
    assign w_ramp_re = w_accept && (i_func == gcrb_pkg::FUNC_READ);

    gcrb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (RAMP_SIZE)
    ) u_ramp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ramp_we),
        .i_wr_addr (r_t),
        .i_wr_data (w_ramp_wdata),
        .i_rd_en   (w_ramp_re),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_ramp_rdata)
    );

    // sequencer: stop loads, ramp fill and read responses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // response taken, unless a new one loads in the same cycle
            if (r_out_valid && i_out_ready && (r_state != S_RDW)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_func == gcrb_pkg::FUNC_READ) begin
                            r_state <= S_RDW;
                        end else begin
                            if (r_count == '0) begin
                                r_count    <= CW'(1);
                                r_last_off <= w_off;
                            end else if ((r_last_off < w_off) && (r_count < CW'(MAX_STOPS))) begin
                                r_count    <= r_count + 1'b1;
                                r_last_off <= w_off;
                            end
                            if (i_last_stop) begin
                                r_i     <= '0;
                                r_t     <= '0;
                                r_state <= S_FRD;
                            end
                        end
                    end
                end
                S_RDW: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= r_built ? w_ramp_rdata : '0;
                        r_out_built <= r_built;
                        r_state     <= S_IDLE;
                    end
                end
                S_FRD: begin
                    r_state <= S_FMUL;
                end
                S_FMUL: begin
                    r_e     <= w_prod[gcrb_pkg::Q_FRAC +: IW];
                    r_cb    <= w_stop_rdata[COLOR_W-1:0];
                    r_state <= S_FNEXT;
                end
                S_FNEXT: begin
                    r_len <= r_e - r_s;
                    r_ch  <= '0;
                    if (r_i == '0) begin
                        r_state <= S_HEAD;
                    end else if (r_e == r_s) begin
                        r_state <= S_FDONE;
                    end else begin
                        r_state <= S_DVLD;
                    end
                end
                S_HEAD: begin
                    if (r_t == r_e) begin
                        r_state <= S_FDONE;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_DVLD: begin
                    r_neg[r_ch] <= (w_b_ch < w_a_ch);
                    r_dvd       <= (w_b_ch < w_a_ch) ? (w_a_ch - w_b_ch) : (w_b_ch - w_a_ch);
                    r_drem      <= '0;
                    r_bit       <= '0;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    r_dvd  <= {r_dvd[CH_W-2:0], w_q_bit};
                    r_drem <= w_rem_nx;
                    r_bit  <= r_bit + 1'b1;
                    if (r_bit == BW'(CH_W - 1)) begin
                        r_qstep[r_ch] <= {r_dvd[CH_W-2:0], w_q_bit};
                        r_rstep[r_ch] <= w_rem_nx;
                        if (r_ch == CHW'(NUM_CH - 1)) begin
                            for (int c = 0; c < NUM_CH; c++) begin
                                r_qacc[c] <= '0;
                                r_racc[c] <= '0;
                            end
                            r_state <= S_SEG;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_DVLD;
                        end
                    end
                end
                S_SEG: begin
                    if (r_t == r_e) begin
                        r_state <= S_FDONE;
                    end else begin
                        r_t <= r_t + 1'b1;
                        // step k by one: remainder wraps at len, carry into quotient
                        for (int c = 0; c < NUM_CH; c++) begin
                            if (({1'b0, r_racc[c]} + {1'b0, r_rstep[c]}) >= {1'b0, r_len}) begin
                                r_racc[c] <= IW'({1'b0, r_racc[c]} + {1'b0, r_rstep[c]}
                                                 - {1'b0, r_len});
                                r_qacc[c] <= r_qacc[c] + r_qstep[c] + 1'b1;
                            end else begin
                                r_racc[c] <= r_racc[c] + r_rstep[c];
                                r_qacc[c] <= r_qacc[c] + r_qstep[c];
                            end
                        end
                    end
                end
                S_FDONE: begin
                    r_s  <= r_e;
                    r_ca <= r_cb;
                    if (w_is_last) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_TAIL: begin
                    if (r_t == LAST_IDX) begin
                        r_built <= 1'b1;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_red   = r_out_col[0*CH_W +: CH_W];
    assign o_entry_green = r_out_col[1*CH_W +: CH_W];
    assign o_entry_blue  = r_out_col[2*CH_W +: CH_W];
    assign o_entry_alpha = r_out_col[3*CH_W +: CH_W];
    assign o_ramp_ready  = r_out_built;

    // stop list never overflows
    `ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_STOPS))
    // a fill always works on a nonempty stop list
    `ASSERT_HOLDS(a_fill_has_stops, i_clk, i_rst_n, w_ramp_we, r_count != '0)
    // segment writes stay inside the segment
    `ASSERT_HOLDS(a_seg_range, i_clk, i_rst_n, r_state == S_SEG, (r_t >= r_s) && (r_t <= r_e))
    // finishing the tail marks the ramp built and empties the stop list
    `ASSERT_NEXT(a_fill_end, i_clk, i_rst_n, (r_state == S_TAIL) && (r_t == LAST_IDX),
                 r_built && (r_count == '0) && (r_state == S_IDLE))

endmodule
